// ===== rtl/adc_reading_converter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// ADC reading converter assertion macros
// Concurrent check wrappers on clk_i, ADCRC_ASSERT disabled while rst_ni is low; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ADC_READING_CONVERTER_UNIT_ASSERT_SVH
`define ADC_READING_CONVERTER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define ADCRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("adcrc check failed");
`define ADCRC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("adcrc check failed");
`else
`define ADCRC_ASSERT(lbl, prop)
`define ADCRC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/adcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// ADC reading converter package
// Widths, codes, pipeline side-band type and thermistor coefficients.
// ----------------------------------------------------------------------------
package adcrc_pkg;

  localparam int CodeBits  = 10;
  localparam int GainBits  = 24;
  localparam int AccBits   = 48;
  localparam int NumBits   = 51;
  localparam int DenBits   = 27;
  localparam int RBits     = 23;
  localparam int PolySteps = 5;
  localparam int HalfBits  = 24;

  localparam logic [DenBits-1:0] SupplyQ24 = DenBits'(5 << 24);
  localparam logic [GainBits-1:0] GainReset = GainBits'(41943);

  typedef enum logic [1:0] {
    KIND_VOLT = 2'd0,
    KIND_CURR = 2'd1,
    KIND_TEMP = 2'd2,
    KIND_BAD  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_PIN = 2'd1,
    ST_SAT = 2'd2,
    ST_BAD = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_VGAIN  = 2'd0,
    REG_IGAIN  = 2'd1,
    REG_REFLSB = 2'd2,
    REG_NONE   = 2'd3
  } reg_e;

  typedef struct packed {
    logic                       vld;
    kind_e                      kind;
    logic                       pin;
    logic                       ovf;
    logic signed [AccBits-1:0]  val;
  } side_t;

  // Q.24 coefficients, highest power first
  function automatic logic signed [AccBits-1:0] poly_coef(input int k);
    logic signed [AccBits-1:0] c;
    case (k)
      0:       c = -48'sd721;
      1:       c =  48'sd67443;
      2:       c = -48'sd2356144;
      3:       c =  48'sd38917103;
      4:       c = -48'sd333996556;
      default: c =  48'sd1625407306;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/adcrc_div.sv =====
// ----------------------------------------------------------------------------
// ADC reading converter divider
// Restoring divider, one quotient bit per stage, with range check up front.
// ----------------------------------------------------------------------------
module adcrc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  adcrc_pkg::side_t                side_i,
  input  logic [adcrc_pkg::NumBits-1:0]   num_i,
  input  logic [adcrc_pkg::DenBits-1:0]   den_i,
  output adcrc_pkg::side_t                side_o,
  output logic [adcrc_pkg::RBits-1:0]     quo_o
);
  import adcrc_pkg::*;

  side_t              side_q [0:RBits];
  logic [NumBits-1:0] rem_q  [0:RBits];
  logic [DenBits-1:0] den_q  [0:RBits];
  logic [RBits-1:0]   quo_q  [0:RBits];

  side_t side0_d;
  always_comb begin
    side0_d     = side_i;
    side0_d.ovf = num_i >= (NumBits'(den_i) << RBits);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q[0] <= '0;
      rem_q[0]  <= '0;
      den_q[0]  <= '0;
      quo_q[0]  <= '0;
    end else if (en_i) begin
      side_q[0] <= side0_d;
      rem_q[0]  <= num_i;
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
    end
  end

  for (genvar j = 1; j <= RBits; j++) begin : g_bit
    localparam int Sh = RBits - j;
    logic [NumBits-1:0] dsh;
    logic               take;
    assign dsh  = NumBits'(den_q[j-1]) << Sh;
    assign take = rem_q[j-1] >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[j] <= '0;
        rem_q[j]  <= '0;
        den_q[j]  <= '0;
        quo_q[j]  <= '0;
      end else if (en_i) begin
        side_q[j]     <= side_q[j-1];
        rem_q[j]      <= take ? (rem_q[j-1] - dsh) : rem_q[j-1];
        den_q[j]      <= den_q[j-1];
        quo_q[j]      <= quo_q[j-1] | (RBits'(take) << Sh);
      end
    end
  end

  assign side_o = side_q[RBits];
  assign quo_o  = quo_q[RBits];

endmodule

// ===== rtl/adcrc_poly.sv =====
// ----------------------------------------------------------------------------
// ADC reading converter polynomial
// Horner evaluation, two stages per step: split multiply, then round and add.
// ----------------------------------------------------------------------------
module adcrc_poly (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  adcrc_pkg::side_t                      side_i,
  input  logic [adcrc_pkg::RBits-1:0]           r_i,
  output adcrc_pkg::side_t                      side_o,
  output logic signed [adcrc_pkg::AccBits-1:0]  acc_o
);
  import adcrc_pkg::*;

  localparam int PBits = HalfBits + RBits;

  side_t                     sa_q  [0:PolySteps-1];
  logic [RBits-1:0]          ra_q  [0:PolySteps-1];
  logic                      nega_q[0:PolySteps-1];
  logic [PBits-1:0]          pl_q  [0:PolySteps-1];
  logic [PBits-1:0]          ph_q  [0:PolySteps-1];
  side_t                     sb_q  [0:PolySteps-1];
  logic [RBits-1:0]          rb_q  [0:PolySteps-1];
  logic signed [AccBits-1:0] accb_q[0:PolySteps-1];

  for (genvar k = 0; k < PolySteps; k++) begin : g_step
    side_t                     s_in;
    logic [RBits-1:0]          r_in;
    logic signed [AccBits-1:0] acc_in;
    logic [AccBits-1:0]        mag;
    logic [PBits+HalfBits:0]   prod;
    logic [AccBits-1:0]        rnd;
    logic signed [AccBits-1:0] acc_d;

    if (k == 0) begin : g_first
      assign s_in   = side_i;
      assign r_in   = r_i;
      assign acc_in = poly_coef(0);
    end else begin : g_next
      assign s_in   = sb_q[k-1];
      assign r_in   = rb_q[k-1];
      assign acc_in = accb_q[k-1];
    end

    assign mag = acc_in[AccBits-1] ? AccBits'(-acc_in) : AccBits'(acc_in);

    assign prod = {1'b0, ph_q[k], {HalfBits{1'b0}}} + (PBits + HalfBits + 1)'(pl_q[k])
                + (PBits + HalfBits + 1)'(1 << 15);
    assign rnd   = prod[AccBits+15:16];
    assign acc_d = (nega_q[k] ? -$signed(rnd) : $signed(rnd)) + poly_coef(k + 1);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sa_q[k]   <= '0;
        ra_q[k]   <= '0;
        nega_q[k] <= 1'b0;
        pl_q[k]   <= '0;
        ph_q[k]   <= '0;
        sb_q[k]   <= '0;
        rb_q[k]   <= '0;
        accb_q[k] <= '0;
      end else if (en_i) begin
        sa_q[k]   <= s_in;
        ra_q[k]   <= r_in;
        nega_q[k] <= acc_in[AccBits-1];
        pl_q[k]   <= PBits'(mag[HalfBits-1:0]) * PBits'(r_in);
        ph_q[k]   <= PBits'(mag[AccBits-1:HalfBits]) * PBits'(r_in);
        sb_q[k]   <= sa_q[k];
        rb_q[k]   <= ra_q[k];
        accb_q[k] <= acc_d;
      end
    end
  end

  assign side_o = sb_q[PolySteps-1];
  assign acc_o  = accb_q[PolySteps-1];

endmodule

// ===== rtl/adc_reading_converter_unit.sv =====
// ----------------------------------------------------------------------------
// ADC reading converter
// Turns a 10-bit ADC code into volts, amperes or degrees Celsius, Q16.16.
//
//   channel   dir   tdata              tuser
//   s_axis    in    code [9:0]         kind [1:0]
//   m_axis    out   value [31:0]       status [1:0]
//   cfg       in    register write, index cfg_idx_i, data cfg_data_i
//
// One item per cycle while the output is not stalled; an item passes through 37
// register stages, the output register being the last of them.
// Most of these stages are in the one-bit-per-stage divider and the Horner stages.
// All stages advance together; a stalled output freezes the whole pipeline.
// Reset clears the valid bits and loads the gain registers.
// ----------------------------------------------------------------------------
`include "adc_reading_converter_unit_assert.svh"
module adc_reading_converter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // code [9:0], zero fill
  input  logic [1:0]  s_axis_tuser,   // kind [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // value [31:0]
  output logic [1:0]  m_axis_tuser    // status [1:0]
);
  import adcrc_pkg::*;

  logic [GainBits-1:0] vgain_q, igain_q, reflsb_q;
  logic                en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vgain_q  <= GainReset;
      igain_q  <= GainReset;
      reflsb_q <= GainReset;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_VGAIN:  vgain_q  <= cfg_data_i;
        REG_IGAIN:  igain_q  <= cfg_data_i;
        REG_REFLSB: reflsb_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  logic                  m_vld_q;
  logic [31:0]           m_data_q;
  status_e               m_st_q;

  assign en            = !m_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: code times gain
  kind_e                  in_kind;
  logic [CodeBits-1:0]    in_code;
  logic signed [CodeBits:0] code_s;
  logic signed [GainBits:0] gain_s;
  logic signed [CodeBits+GainBits+1:0] prod_s;
  side_t                  s1_d, s1_q;

  assign in_kind = kind_e'(s_axis_tuser);
  assign in_code = s_axis_tdata[CodeBits-1:0];

  always_comb begin
    code_s = (in_kind == KIND_CURR) ? $signed({in_code[CodeBits-1], in_code})
                                    : $signed({1'b0, in_code});
    case (in_kind)
      KIND_VOLT: gain_s = $signed({1'b0, vgain_q});
      KIND_CURR: gain_s = $signed({1'b0, igain_q});
      default:   gain_s = $signed({1'b0, reflsb_q});
    endcase
    prod_s    = code_s * gain_s;
    s1_d      = '0;
    s1_d.vld  = s_axis_tvalid;
    s1_d.kind = in_kind;
    s1_d.val  = AccBits'(prod_s);
  end

  // stage 2: supply check, divider operands
  logic [33:0]          pin_v;
  logic [33:0]          pin_121;
  side_t                s2_d, s2_q;
  logic [NumBits-1:0]   num_d, num_q;
  logic [DenBits-1:0]   den_d, den_q;

  always_comb begin
    pin_v    = s1_q.val[33:0];
    pin_121  = 34'(pin_v[DenBits-1:0]) * 34'd121;
    s2_d     = s1_q;
    s2_d.pin = pin_v >= 34'(SupplyQ24);
    num_d    = NumBits'({pin_121, 16'b0});
    den_d    = SupplyQ24 - pin_v[DenBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      s2_q  <= '0;
      num_q <= '0;
      den_q <= '0;
    end else if (en) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  side_t             sdiv;
  logic [RBits-1:0]  res_r;
  side_t             spoly;
  logic signed [AccBits-1:0] poly_acc;

  adcrc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (s2_q),
    .num_i  (num_q),
    .den_i  (den_q),
    .side_o (sdiv),
    .quo_o  (res_r)
  );

  adcrc_poly u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (sdiv),
    .r_i    (res_r),
    .side_o (spoly),
    .acc_o  (poly_acc)
  );

  // output stage: round to Q16.16, saturate, pick status
  logic signed [AccBits-1:0] q24;
  logic [AccBits-1:0]        qmag;
  logic [AccBits:0]          qsum;
  logic [40:0]               qrnd;
  logic signed [41:0]        qv;
  logic [31:0]               out_d;
  status_e                   st_d;

  always_comb begin
    q24  = (spoly.kind == KIND_TEMP) ? poly_acc : spoly.val;
    qmag = q24[AccBits-1] ? AccBits'(-q24) : AccBits'(q24);
    qsum = (AccBits+1)'(qmag) + (AccBits+1)'(128);
    qrnd = qsum[AccBits:8];
    qv   = q24[AccBits-1] ? -$signed({1'b0, qrnd}) : $signed({1'b0, qrnd});
    st_d  = ST_OK;
    out_d = qv[31:0];
    if (qv > 42'sd2147483647) begin
      out_d = 32'h7fff_ffff;
      st_d  = ST_SAT;
    end else if (qv < -42'sd2147483648) begin
      out_d = 32'h8000_0000;
      st_d  = ST_SAT;
    end
    case (spoly.kind)
      KIND_BAD: begin
        out_d = '0;
        st_d  = ST_BAD;
      end
      KIND_TEMP: begin
        if (spoly.pin) begin
          out_d = '0;
          st_d  = ST_PIN;
        end else if (spoly.ovf) begin
          out_d = 32'h8000_0000;
          st_d  = ST_SAT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q  <= 1'b0;
      m_data_q <= '0;
      m_st_q   <= ST_OK;
    end else if (en) begin
      m_vld_q  <= spoly.vld;
      m_data_q <= out_d;
      m_st_q   <= st_d;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_st_q;

  `ADCRC_ASSERT(a_bad_zero, m_axis_tvalid && m_axis_tuser == ST_BAD |-> m_axis_tdata == 32'd0)
  `ADCRC_ASSERT(a_pin_zero, m_axis_tvalid && m_axis_tuser == ST_PIN |-> m_axis_tdata == 32'd0)
  `ADCRC_ASSERT(a_empty_ready, !m_axis_tvalid |-> s_axis_tready)
  `ADCRC_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !m_axis_tvalid || $past(rst_ni))

endmodule
